>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Field widths, command and status codes, and sequencer states of the list.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int COMMAND_W  = 2;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 4;
    localparam int LENGTH_W   = 5;

    localparam logic [COMMAND_W-1:0] CMD_INSERT    = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_REMOVE_AT = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_REMOVE_EQ = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [6:0]
    {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SHIFT_UP = 7'b0001000,
        S_SHIFT_DN = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

endpackage

>>> sv/ordered_list_engine_top.sv
// A rejected command goes from S_DECIDE straight to S_DONE with its status.
// Insert at p shifts entries p..length-1 up (S_SHIFT_UP), then writes at p (S_PUT);
// remove reads p or scans from 0 for a match, then shifts any later entries down.
// One transaction at a time, one RAM read and one RAM write per cycle;
// the next command is taken the cycle after the result is taken.
// Reset (rst_n, async, active low) empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list with positional insert/remove and remove-by-value,
// run by a small sequencer over one RAM that shifts entries one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_engine_top
    import olist_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [COMMAND_W-1:0]       command,
    input  logic [POSITION_W-1:0]      position,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  removed_value,
    output logic [FOUND_W-1:0]         found_position,
    output logic [LENGTH_W-1:0]        list_length
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;
    localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [COMMAND_W-1:0]   cmd_reg;
    logic [POSITION_W-1:0]  pos_reg;
    logic [VALUE_W-1:0]     val_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     rv_reg, rv_next;
    logic [IDX_W-1:0]       fp_reg, fp_next;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [VALUE_W-1:0]     ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [VALUE_W-1:0]     ram_rd_data;

    logic [EXT_W-1:0]       pos_ext, cnt_ext, idx_ext;
    logic [EXT_W-1:0]       pos_p1, cnt_p1, cnt_m1, idx_p1, idx_p2, idx_m2;
    logic                   accept, scan_hit;

    assign accept  = cmd_valid && !cmd_stall;
    assign pos_ext = EXT_W'(pos_reg);
    assign cnt_ext = EXT_W'(count_reg);
    assign idx_ext = EXT_W'(idx_reg);
    assign pos_p1  = pos_ext + EXT_W'(1);
    assign cnt_p1  = cnt_ext + EXT_W'(1);
    assign cnt_m1  = cnt_ext - EXT_W'(1);
    assign idx_p1  = idx_ext + EXT_W'(1);
    assign idx_p2  = idx_ext + EXT_W'(2);
    assign idx_m2  = idx_ext - EXT_W'(2);
    assign scan_hit = (cmd_reg == CMD_REMOVE_AT) || (ram_rd_data == val_reg);

    olist_ram
    #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        fp_next     = fp_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                status_next = ST_OK;
                rv_next     = '0;
                fp_next     = '0;
                state_next  = S_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (cnt_ext >= CAP_EXT)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cnt_m1[IDX_W-1:0];
                            idx_next    = count_reg[IDX_W-1:0];
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    CMD_REMOVE_AT:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = pos_ext[IDX_W-1:0];
                            idx_next    = pos_ext[IDX_W-1:0];
                            state_next  = S_SCAN;
                        end
                    end
                    CMD_REMOVE_EQ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            idx_next    = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = ST_BAD;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    rv_next = ram_rd_data;
                    fp_next = idx_reg;
                    if (idx_p1 == cnt_ext)
                    begin
                        count_next = cnt_m1[CNT_W-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_p1[IDX_W-1:0];
                        state_next  = S_SHIFT_DN;
                    end
                end
                else if (idx_p1 == cnt_ext)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_p1[IDX_W-1:0];
                    idx_next    = idx_p1[IDX_W-1:0];
                end
            end

            S_SHIFT_DN:
            begin
                ram_wr_en = 1'b1;
                if (idx_p2 == cnt_ext)
                begin
                    count_next = cnt_m1[CNT_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_p2[IDX_W-1:0];
                    idx_next    = idx_p1[IDX_W-1:0];
                end
            end

            S_SHIFT_UP:
            begin
                ram_wr_en = 1'b1;
                if (idx_ext == pos_p1)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_m2[IDX_W-1:0];
                    idx_next    = idx_m2[IDX_W-1:0] + IDX_W'(1);
                end
            end

            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_ext[IDX_W-1:0];
                ram_wr_data = val_reg;
                count_next  = cnt_p1[CNT_W-1:0];
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= value;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        fp_reg     <= fp_next;
    end

    assign cmd_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = (state_reg == S_DONE);
    assign status         = status_reg;
    assign removed_value  = rv_reg;
    assign found_position = FOUND_W'(fp_reg);
    assign list_length    = LENGTH_W'(count_reg);

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, EXT_W'(count_reg) <= CAP_EXT)
    `ASSERT_NEXT(a_accept_decide, clk, rst_n, accept, state_reg == S_DECIDE)
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, rsp_valid && (status != ST_OK), (rv_reg == '0) && (fp_reg == '0))
    `ASSERT_IMPLY(a_full_count, clk, rst_n, rsp_valid && (status == ST_FULL), EXT_W'(count_reg) == CAP_EXT)
    `ASSERT_IMPLY(a_write_states, clk, rst_n, ram_wr_en, (state_reg == S_SHIFT_UP) || (state_reg == S_SHIFT_DN) || (state_reg == S_PUT))

endmodule

>>> sv/olist_ram.sv
// ----------------------------------------------------------------------------
// olist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olist_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
